/* rtl/sigmoidal_angle_grading_transform_macros.svh */
// Assertion macros shared by the grading transform RTL.
`ifndef SIGMOIDAL_ANGLE_GRADING_TRANSFORM_MACROS_SVH
`define SIGMOIDAL_ANGLE_GRADING_TRANSFORM_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define SAGT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sagt assertion failed");
// Next-cycle implication, disabled in reset.
`define SAGT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sagt assertion failed");
`else
`define SAGT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SAGT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/sagt_pkg.sv */
// Package: types and constants of the grading transform.
`timescale 1ns / 1ps
`default_nettype none
package sagt_pkg;

  localparam int GRADING_ORDER = 8;

  // Q.30 and Q5.27 constants
  localparam longint ONE_L  = 64'sd1073741824;
  localparam longint B_L    = ONE_L / GRADING_ORDER;
  localparam longint A_L    = ONE_L / 2 - B_L;

  localparam logic [30:0] ONE_Q30  = 31'(ONE_L);
  localparam logic [29:0] HALF_Q30 = 30'(ONE_L / 2);
  localparam logic [30:0] B_COEF   = 31'(B_L);
  localparam logic [30:0] A_COEF   = 31'(A_L);
  localparam logic [31:0] A3_COEF  = 32'(3 * A_L);

  localparam logic [29:0] PI_Q     = 30'd421657428;
  localparam logic [29:0] TWO_PI_Q = 30'd843314856;
  localparam logic signed [31:0] TWO_PI_S  = 32'sd843314856;
  localparam logic signed [31:0] ANGLE_MIN = -32'sd843314856;
  localparam logic signed [31:0] ANGLE_MAX = 32'sd1686629711;
  localparam logic [31:0] RESULT_MAX = 32'h7FFF_FFFF;

  // 2^59 / pi rounded up; estimate of |s - pi| * 2^30 / pi is off by at most one
  localparam longint RECIP_L  = (longint'(1) <<< 59) / 421657428 + 1;
  localparam logic [30:0] U_RECIP = 31'(RECIP_L);

  // divider: one quotient bit per stage, plus an input stage
  localparam int DIV_QBITS = 32;
  localparam int NPOW      = GRADING_ORDER - 1;

  // front 5, cubic 4, two dividers, powers + operand prep, output reg
  localparam int SAGT_LATENCY = 5 + 4 + 2 * (DIV_QBITS + 1) + NPOW + 2 + 1;

  typedef enum logic [1:0] {
    FOLD_NONE,
    FOLD_UP,
    FOLD_DOWN
  } sagt_fold_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic               func;
  } sagt_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               clamped;
  } sagt_out_t;

  // sideband that rides along the pipe
  typedef struct packed {
    logic        func;
    logic        clamped;
    sagt_fold_t  fold;
    logic        neg;
    logic        le;
    logic [30:0] mx;
    logic [31:0] dvdu;
  } sagt_ctx_t;

endpackage
`default_nettype wire

/* rtl/sigmoidal_angle_grading_transform.sv */
// Top level of the sigmoidal angle grading transform.
`timescale 1ns / 1ps
`default_nettype none
`include "sigmoidal_angle_grading_transform_macros.svh"
// Usage:
//   Drive in_data (angle in signed Q5.27, func 0 = map, 1 = derivative) and
//   pulse start. An item is taken at each edge where start is high and busy
//   is low; busy stays low, so one item can enter every cycle.
//   Each result appears on out_data for one cycle with out_valid high,
//   in input order. Pipeline: 5 front stages (clamp, fold, offset from pi,
//   reciprocal estimate of u, correction), 4 cubic stages, the 33-stage
//   min/max ratio divider, p-1 power steps, 2 operand stages, the 33-stage
//   final divider and the output register.
//   Throughput: one item per cycle, sustained.
//   Angles outside [-2pi, 4pi) are clamped and out_data.clamped is set.
//   The derivative saturates at the largest positive Q5.27 value.
//   Reset (rst_n low, synchronous) clears all valid bits; items in flight
//   are dropped and no strobe follows. Datapath registers are not reset.
//   There is no stall: the receiver must take each result as it appears.
module sigmoidal_angle_grading_transform import sagt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sagt_in_t  in_data,
  output logic      out_valid,
  output sagt_out_t out_data
);

  // fully pipelined: never busy
  assign busy = 1'b0;

  // u magnitude = |s - pi| * 2^30 / pi, sign rides in the context
  logic                 f_valid;
  logic [DIV_QBITS-1:0] f_u;
  sagt_ctx_t            f_ctx;

  sagt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (start & ~busy),
    .i_data  (in_data),
    .o_valid (f_valid),
    .o_u     (f_u),
    .o_ctx   (f_ctx)
  );

  logic                 v_valid;
  logic [63:0]          v_num;
  logic [32:0]          v_den;
  sagt_ctx_t            v_ctx;

  sagt_vcalc u_vcalc (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (f_valid),
    .i_quo   (f_u),
    .i_ctx   (f_ctx),
    .o_valid (v_valid),
    .o_num   (v_num),
    .o_den   (v_den),
    .o_ctx   (v_ctx)
  );

  // q = min * 2^30 / max
  logic                 d1_valid, d1_ovf;
  logic [DIV_QBITS-1:0] d1_quo;
  sagt_ctx_t            d1_ctx;

  sagt_div u_div_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (v_valid),
    .i_num   (v_num),
    .i_den   (v_den),
    .i_ctx   (v_ctx),
    .o_valid (d1_valid),
    .o_quo   (d1_quo),
    .o_ovf   (d1_ovf),
    .o_ctx   (d1_ctx)
  );

  logic                 p_valid;
  logic [63:0]          p_num;
  logic [32:0]          p_den;
  sagt_ctx_t            p_ctx;

  sagt_pow u_pow (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (d1_valid),
    .i_quo   (d1_quo),
    .i_ctx   (d1_ctx),
    .o_valid (p_valid),
    .o_num   (p_num),
    .o_den   (p_den),
    .o_ctx   (p_ctx)
  );

  // map: q^p / (1 + q^p); derivative: scaled numerator / denominator
  logic                 d2_valid, d2_ovf;
  logic [DIV_QBITS-1:0] d2_quo;
  sagt_ctx_t            d2_ctx;

  sagt_div u_div_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (p_valid),
    .i_num   (p_num),
    .i_den   (p_den),
    .i_ctx   (p_ctx),
    .o_valid (d2_valid),
    .o_quo   (d2_quo),
    .o_ovf   (d2_ovf),
    .o_ctx   (d2_ctx)
  );

  // final scale / offset / saturation
  logic [30:0]        ratio;
  logic [60:0]        p_map;
  logic signed [31:0] map_base, map_res;
  logic [31:0]        deriv_res;
  sagt_out_t          out_nxt;
  logic               out_valid_r;
  sagt_out_t          out_data_r;

  always_comb begin
    // the ratio divide never overflows; only the last one can
    ratio    = d2_ctx.le ? d2_quo[30:0] : (ONE_Q30 - d2_quo[30:0]);
    p_map    = 61'(TWO_PI_Q) * 61'(ratio);
    map_base = $signed({1'b0, p_map[60:30]});
    unique case (d2_ctx.fold)
      FOLD_UP:   map_res = map_base - TWO_PI_S;
      FOLD_DOWN: map_res = map_base + TWO_PI_S;
      FOLD_NONE: map_res = map_base;
      default:   map_res = map_base;
    endcase
    deriv_res = (d2_ovf || d2_quo[DIV_QBITS-1]) ? RESULT_MAX : d2_quo;
    out_nxt.result  = d2_ctx.func ? $signed(deriv_res) : map_res;
    out_nxt.clamped = d2_ctx.clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SAGT_ASSERT_IMP(a_latency, clk, rst_n, out_valid, $past(start, SAGT_LATENCY))
  `SAGT_ASSERT_IMP(a_early_div, clk, rst_n, d1_valid, !d1_ovf)

endmodule
`default_nettype wire

/* rtl/sagt_front.sv */
// Front end: clamp, fold into [0,2pi), scaled offset magnitude u from pi.
`timescale 1ns / 1ps
`default_nettype none
`include "sigmoidal_angle_grading_transform_macros.svh"
module sagt_front import sagt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 i_valid,
  input  sagt_in_t             i_data,
  output logic                 o_valid,
  output logic [DIV_QBITS-1:0] o_u,
  output sagt_ctx_t            o_ctx
);

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [31:0] s1_r, s1_nxt;
  logic               cl1_nxt;
  sagt_ctx_t          c1_r, c2_r, c3_r, c1_nxt, c2_nxt, c3_nxt;
  sagt_ctx_t          c4_r, c5_r;
  logic [29:0]        s2_r, s2_nxt;
  logic [29:0]        mag3_r, mag3_nxt;
  logic signed [30:0] diff;
  logic [60:0]        p_est;
  logic [29:0]        mag4_r;
  logic [31:0]        q4_r;
  logic [61:0]        p_chk;
  logic               over;
  logic [31:0]        u5_r, u5_nxt;

  always_comb begin
    s1_nxt  = i_data.angle;
    cl1_nxt = 1'b0;
    priority if (i_data.angle < ANGLE_MIN) begin
      s1_nxt  = ANGLE_MIN;
      cl1_nxt = 1'b1;
    end else if (i_data.angle > ANGLE_MAX) begin
      s1_nxt  = ANGLE_MAX;
      cl1_nxt = 1'b1;
    end else begin
      s1_nxt  = i_data.angle;
    end
    c1_nxt         = '0;
    c1_nxt.func    = i_data.func;
    c1_nxt.clamped = cl1_nxt;
  end

  always_comb begin
    c2_nxt = c1_r;
    priority if (s1_r < 0) begin
      s2_nxt      = 30'(s1_r + TWO_PI_S);
      c2_nxt.fold = FOLD_UP;
    end else if (s1_r < TWO_PI_S) begin
      s2_nxt      = s1_r[29:0];
      c2_nxt.fold = FOLD_NONE;
    end else begin
      s2_nxt      = 30'(s1_r - TWO_PI_S);
      c2_nxt.fold = FOLD_DOWN;
    end
  end

  always_comb begin
    diff       = $signed({1'b0, s2_r}) - $signed({1'b0, PI_Q});
    c3_nxt     = c2_r;
    c3_nxt.neg = diff[30];
    mag3_nxt   = diff[30] ? 30'(-diff) : diff[29:0];
  end

  // u = floor(mag * 2^30 / pi): reciprocal estimate, then one correction step
  assign p_est = 61'(mag3_r) * 61'(U_RECIP);

  always_comb begin
    p_chk  = 62'(q4_r) * 62'(PI_Q);
    over   = (p_chk > 62'({mag4_r, 30'b0}));
    u5_nxt = q4_r - 32'(over);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= i_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= s1_nxt;
    c1_r   <= c1_nxt;
    s2_r   <= s2_nxt;
    c2_r   <= c2_nxt;
    mag3_r <= mag3_nxt;
    c3_r   <= c3_nxt;
    mag4_r <= mag3_r;
    q4_r   <= p_est[60:29];
    c4_r   <= c3_r;
    u5_r   <= u5_nxt;
    c5_r   <= c4_r;
  end

  assign o_valid = v5_r;
  assign o_u     = u5_r;
  assign o_ctx   = c5_r;

  `SAGT_ASSERT_IMP(a_fold_range, clk, rst_n, v2_r, s2_r < TWO_PI_Q)
  `SAGT_ASSERT_NXT(a_front_flow, clk, rst_n, v1_r, v2_r)

endmodule
`default_nettype wire

/* rtl/sagt_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
`include "sigmoidal_angle_grading_transform_macros.svh"
module sagt_div import sagt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 i_valid,
  input  logic [63:0]          i_num,
  input  logic [32:0]          i_den,
  input  sagt_ctx_t            i_ctx,
  output logic                 o_valid,
  output logic [DIV_QBITS-1:0] o_quo,
  output logic                 o_ovf,
  output sagt_ctx_t            o_ctx
);

  logic                 v_r   [0:DIV_QBITS];
  logic [32:0]          rem_r [0:DIV_QBITS];
  logic [31:0]          low_r [0:DIV_QBITS];
  logic [DIV_QBITS-1:0] quo_r [0:DIV_QBITS];
  logic [32:0]          den_r [0:DIV_QBITS];
  logic                 ovf_r [0:DIV_QBITS];
  sagt_ctx_t            ctx_r [0:DIV_QBITS];

  // input stage: upper half is the starting remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= {1'b0, i_num[63:32]};
    low_r[0] <= i_num[31:0];
    quo_r[0] <= '0;
    den_r[0] <= i_den;
    ovf_r[0] <= ({1'b0, i_num[63:32]} >= i_den);
    ctx_r[0] <= i_ctx;
  end

  for (genvar k = 0; k < DIV_QBITS; k++) begin : g_step
    logic [33:0] trial;
    logic [33:0] diff;
    logic        ge;

    assign trial = {rem_r[k], low_r[k][31]};
    assign diff  = trial - {1'b0, den_r[k]};
    assign ge    = (trial >= {1'b0, den_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? diff[32:0] : trial[32:0];
      low_r[k+1] <= {low_r[k][30:0], 1'b0};
      quo_r[k+1] <= {quo_r[k][DIV_QBITS-2:0], ge};
      den_r[k+1] <= den_r[k];
      ovf_r[k+1] <= ovf_r[k];
      ctx_r[k+1] <= ctx_r[k];
    end
  end

  assign o_valid = v_r[DIV_QBITS];
  assign o_quo   = quo_r[DIV_QBITS];
  assign o_ovf   = ovf_r[DIV_QBITS];
  assign o_ctx   = ctx_r[DIV_QBITS];

  `SAGT_ASSERT_IMP(a_rem_bound, clk, rst_n, v_r[DIV_QBITS] && !ovf_r[DIV_QBITS], rem_r[DIV_QBITS] < den_r[DIV_QBITS])

endmodule
`default_nettype wire

/* rtl/sagt_vcalc.sv */
// Cubic v(u), its slope, and the max/min split for the ratio divide.
`timescale 1ns / 1ps
`default_nettype none
`include "sigmoidal_angle_grading_transform_macros.svh"
module sagt_vcalc import sagt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 i_valid,
  input  logic [DIV_QBITS-1:0] i_quo,
  input  sagt_ctx_t            i_ctx,
  output logic                 o_valid,
  output logic [63:0]          o_num,
  output logic [32:0]          o_den,
  output sagt_ctx_t            o_ctx
);

  logic               v1_r, v2_r, v3_r, v4_r;
  logic [30:0]        uabs;
  logic [61:0]        p_uu, p_bu, p_u3, p_au;
  logic [62:0]        p_dv;
  logic [30:0]        u1_r, u2_1_r, tb1_r;
  logic [30:0]        u3_2_r, tb2_r;
  logic [30:0]        ta3_r, tb3_r;
  sagt_ctx_t          c1_r, c2_r, c3_r, c4_r, c2_nxt, c4_nxt;
  logic [31:0]        mag;
  logic signed [33:0] vs_w;
  logic [30:0]        vs, vt, mx4_r, mn4_r;

  assign uabs = i_quo[30:0];
  assign p_uu = 62'(uabs) * 62'(uabs);
  assign p_bu = 62'(B_COEF) * 62'(uabs);

  // stage 2: u^3 and dv/du
  assign p_u3 = 62'(u2_1_r) * 62'(u1_r);
  assign p_dv = 63'(A3_COEF) * 63'(u2_1_r);
  always_comb begin
    c2_nxt      = c1_r;
    c2_nxt.dvdu = 32'(p_dv[62:30]) + 32'(B_COEF);
  end

  // stage 3: A*u^3
  assign p_au = 62'(A_COEF) * 62'(u3_2_r);

  // stage 4: vs, saturated, and the split
  always_comb begin
    mag = {1'b0, ta3_r} + {1'b0, tb3_r};
    if (c3_r.neg) begin
      vs_w = $signed({4'b0, HALF_Q30}) - $signed({2'b0, mag});
    end else begin
      vs_w = $signed({4'b0, HALF_Q30}) + $signed({2'b0, mag});
    end
    priority if (vs_w < 0) begin
      vs = '0;
    end else if (vs_w > $signed({3'b0, ONE_Q30})) begin
      vs = ONE_Q30;
    end else begin
      vs = vs_w[30:0];
    end
    vt        = ONE_Q30 - vs;
    c4_nxt    = c3_r;
    c4_nxt.le = (vs <= vt);
    c4_nxt.mx = (vs > vt) ? vs : vt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= i_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    u1_r   <= uabs;
    u2_1_r <= p_uu[60:30];
    tb1_r  <= p_bu[60:30];
    c1_r   <= i_ctx;
    u3_2_r <= p_u3[60:30];
    tb2_r  <= tb1_r;
    c2_r   <= c2_nxt;
    ta3_r  <= p_au[60:30];
    tb3_r  <= tb2_r;
    c3_r   <= c2_r;
    mx4_r  <= (vs > vt) ? vs : vt;
    mn4_r  <= (vs > vt) ? vt : vs;
    c4_r   <= c4_nxt;
  end

  assign o_valid = v4_r;
  assign o_num   = {3'b0, mn4_r, 30'b0};
  assign o_den   = {2'b0, mx4_r};
  assign o_ctx   = c4_r;

  `SAGT_ASSERT_IMP(a_mx_range, clk, rst_n, v4_r, (mx4_r >= 31'(HALF_Q30)) && (mx4_r <= ONE_Q30) && (mn4_r <= mx4_r))

endmodule
`default_nettype wire

/* rtl/sagt_pow.sv */
// Power chain of q, then operand prep for the map or derivative divide.
`timescale 1ns / 1ps
`default_nettype none
module sagt_pow import sagt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 i_valid,
  input  logic [DIV_QBITS-1:0] i_quo,
  input  sagt_ctx_t            i_ctx,
  output logic                 o_valid,
  output logic [63:0]          o_num,
  output logic [32:0]          o_den,
  output sagt_ctx_t            o_ctx
);

  logic        v_r [1:NPOW];
  logic [30:0] x_r [1:NPOW];
  logic [30:0] q_r [1:NPOW];
  sagt_ctx_t   c_r [1:NPOW];
  logic [30:0] qp1_r;

  for (genvar k = 0; k < NPOW; k++) begin : g_pow
    logic        vin;
    logic [30:0] xin, qin;
    sagt_ctx_t   cin;
    logic [61:0] prod;

    if (k == 0) begin : g_first
      assign vin = i_valid;
      assign xin = i_quo[30:0];
      assign qin = i_quo[30:0];
      assign cin = i_ctx;
    end else begin : g_next
      assign vin = v_r[k];
      assign xin = x_r[k];
      assign qin = q_r[k];
      assign cin = c_r[k];
    end

    assign prod = 62'(xin) * 62'(qin);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      x_r[k+1] <= prod[60:30];
      q_r[k+1] <= qin;
      c_r[k+1] <= cin;
    end

    // the power before the last step is q^(p-1)
    if (k == NPOW - 1) begin : g_last
      always_ff @(posedge clk) begin
        qp1_r <= xin;
      end
    end
  end

  logic        e1_v_r, e2_v_r;
  logic [62:0] p_num;
  logic [61:0] p_m2;
  logic [31:0] opq;
  logic [63:0] p_opq2, p_den, scaled;
  logic [31:0] num1_r, opq1_r;
  logic [30:0] m2_1_r, qp1_1_r;
  logic [32:0] opq2_1_r;
  sagt_ctx_t   c_e1_r, c_e2_r;
  logic [63:0] num2_r, num2_nxt;
  logic [32:0] den2_r, den2_nxt;

  assign p_num  = 63'(c_r[NPOW].dvdu) * 63'(qp1_r);
  assign p_m2   = 62'(c_r[NPOW].mx) * 62'(c_r[NPOW].mx);
  assign opq    = 32'(ONE_Q30) + 32'(x_r[NPOW]);
  assign p_opq2 = 64'(opq) * 64'(opq);

  assign p_den  = 64'(m2_1_r) * 64'(opq2_1_r);
  assign scaled = (64'(num1_r) * 64'(2 * GRADING_ORDER)) << 27;

  always_comb begin
    if (c_e1_r.func) begin
      num2_nxt = scaled;
      den2_nxt = p_den[62:30];
    end else begin
      num2_nxt = {3'b0, qp1_1_r, 30'b0};
      den2_nxt = {1'b0, opq1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
    end else begin
      e1_v_r <= v_r[NPOW];
      e2_v_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    num1_r   <= p_num[61:30];
    m2_1_r   <= p_m2[60:30];
    opq1_r   <= opq;
    opq2_1_r <= p_opq2[62:30];
    qp1_1_r  <= x_r[NPOW];
    c_e1_r   <= c_r[NPOW];
    num2_r   <= num2_nxt;
    den2_r   <= den2_nxt;
    c_e2_r   <= c_e1_r;
  end

  assign o_valid = e2_v_r;
  assign o_num   = num2_r;
  assign o_den   = den2_r;
  assign o_ctx   = c_e2_r;

endmodule
`default_nettype wire
